// File: design/hpp_pkg.sv
// Shared types, constants and helpers for the heater pre-warm policy block.
package hpp_pkg;

	localparam int CHANNELS = 8;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W    = $clog2(CHANNELS + 1);

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	// Heater mode codes.
	localparam logic [1:0] MODE_AUTO     = 2'd0;
	localparam logic [1:0] MODE_FORCE_ON = 2'd1;
	localparam logic [1:0] MODE_FORCE_OFF = 2'd2;
	localparam logic [1:0] MODE_UNUSED   = 2'd3;

	// Heater command codes.
	localparam logic [1:0] HEAT_NONE = 2'd0;
	localparam logic [1:0] HEAT_ON   = 2'd1;
	localparam logic [1:0] HEAT_OFF  = 2'd2;

	// Action codes.
	localparam logic ACT_READING  = 1'b0;
	localparam logic ACT_EVALUATE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WARM_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLD_OFF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STALE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAP      = 3'd5;

	typedef struct packed {
		logic [1:0]  mode;
		logic [14:0] warm_min;
		logic [14:0] cold_off;
		logic [31:0] stale_limit;
		logic [31:0] settle;
		logic [31:0] gap;
	} cfg_t;

	typedef struct packed {
		logic        action;
		logic [2:0]  chan;
		logic        cooler;
		logic [14:0] ctemp;
		logic [31:0] now;
		logic        amb_valid;
		logic [14:0] amb;
		logic        powered;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic        cooler;
		logic [14:0] temp;
		logic [31:0] stamp;
	} slot_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		slot_t            data;
	} slot_wr_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sgn;
	} alu_req_t;

	typedef struct packed {
		logic [1:0]  heater_cmd;
		logic        bank_req;
		logic        warn;
		logic [3:0]  valid_total;
		logic [3:0]  stale_total;
		logic        all_on;
		logic [31:0] dur;
		logic        cold;
		logic        warm;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WARN_SUB,
		ST_WARN_CMP,
		ST_AMB_GT,
		ST_AGE,
		ST_STALE,
		ST_COLD,
		ST_WARM,
		ST_DUR,
		ST_SETTLE,
		ST_AMB_LT,
		ST_DONE
	} state_t;

	function automatic logic [31:0] sx15(input logic [14:0] v);
		return {{17{v[14]}}, v};
	endfunction

endpackage

// File: design/hpp_sub_cmp.sv
// Shared 33-bit subtractor that yields a wrapped difference and a less-than flag.
module hpp_sub_cmp (
	input  hpp_pkg::alu_req_t req,
	output logic [31:0]       diff,
	output logic              lt
);
	import hpp_pkg::*;

	logic [31:0] flip;
	logic [32:0] wide;

	// Flipping both sign bits turns a signed compare into an unsigned one
	// and leaves the wrapped difference unchanged.
	assign flip = {req.sgn, 31'b0};
	assign wide = {1'b0, req.a ^ flip} - {1'b0, req.b ^ flip};
	assign diff = wide[31:0];
	assign lt   = wide[32];

endmodule

// File: design/hpp_slot_store.sv
// Per-channel cache of the latest reading, one write and one read port.
module hpp_slot_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hpp_pkg::slot_wr_t              wr,
	input  logic [hpp_pkg::IDX_W-1:0]      rd_idx,
	output hpp_pkg::slot_t                 rd_data
);
	import hpp_pkg::*;

	logic [CHANNELS-1:0] valid_q;
	logic                cooler_q [CHANNELS];
	logic [14:0]         temp_q   [CHANNELS];
	logic [31:0]         stamp_q  [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			cooler_q[wr.idx] <= wr.data.cooler;
			temp_q[wr.idx]   <= wr.data.temp;
			stamp_q[wr.idx]  <= wr.data.stamp;
		end
	end

	// Payload of a slot never written is only looked at behind its valid bit.
	assign rd_data.valid  = valid_q[rd_idx];
	assign rd_data.cooler = cooler_q[rd_idx];
	assign rd_data.temp   = temp_q[rd_idx];
	assign rd_data.stamp  = stamp_q[rd_idx];

endmodule

// File: design/hpp_ctrl.sv
// Sequencer that steps one evaluate through the shared subtractor, channel by channel.
module hpp_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hpp_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  hpp_pkg::item_t            in_item,
	output hpp_pkg::slot_wr_t         slot_wr,
	output logic [hpp_pkg::IDX_W-1:0] slot_idx,
	input  hpp_pkg::slot_t            slot_rd,
	output hpp_pkg::alu_req_t         alu_req,
	input  logic [31:0]               alu_diff,
	input  logic                      alu_lt,
	input  logic                      out_free,
	output logic                      out_load,
	output hpp_pkg::result_t          out_res
);
	import hpp_pkg::*;

	state_t state_q, state_d;

	item_t            item_q;
	logic [1:0]       mode_q;
	logic [IDX_W-1:0] ch_q;
	logic [31:0]      work_q;
	logic [14:0]      off_thr_q;
	logic [CNT_W-1:0] valid_n_q, stale_n_q;
	logic             all_en_q, all_on_q, cold_q, warm_q, warn_q;
	logic             settle_ok_q, amb_lt_q, entered_q;
	logic [31:0]      all_on_since_q, last_warn_q;
	logic [1:0]       prior_mode_q;
	logic             prior_known_q;

	logic             accept;
	logic             last_ch;
	logic             all_fresh_on;
	logic [31:0]      since_eff;
	logic             in_range;

	assign accept       = in_valid && in_ready;
	assign last_ch      = (ch_q == IDX_W'(CHANNELS - 1));
	assign all_fresh_on = all_en_q && (valid_n_q == CNT_W'(CHANNELS));
	assign since_eff    = (all_on_since_q == 32'd0) ? item_q.now : all_on_since_q;
	assign in_range     = ({29'b0, in_item.chan} < 32'(CHANNELS));
	assign slot_idx     = ch_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_item.action == ACT_READING) begin
						state_d = ST_DONE;
					end else if (cfg.mode != MODE_AUTO) begin
						state_d = ST_WARN_SUB;
					end else begin
						state_d = ST_AMB_GT;
					end
				end
			end
			ST_WARN_SUB: state_d = ST_WARN_CMP;
			ST_WARN_CMP: state_d = ST_DONE;
			ST_AMB_GT:   state_d = ST_AGE;
			ST_AGE: begin
				if (!slot_rd.valid || slot_rd.stamp == 32'd0) begin
					state_d = last_ch ? ST_DUR : ST_AGE;
				end else begin
					state_d = ST_STALE;
				end
			end
			ST_STALE: begin
				if (alu_lt || slot_rd.cooler) begin
					state_d = last_ch ? ST_DUR : ST_AGE;
				end else begin
					state_d = ST_COLD;
				end
			end
			ST_COLD:   state_d = ST_WARM;
			ST_WARM:   state_d = last_ch ? ST_DUR : ST_AGE;
			ST_DUR:    state_d = ST_SETTLE;
			ST_SETTLE: state_d = ST_AMB_LT;
			ST_AMB_LT: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake, slot write and operands of the shared unit.
	always_comb begin
		in_ready          = (state_q == ST_IDLE);
		out_load          = (state_q == ST_DONE) && out_free;
		slot_wr.en        = accept && (in_item.action == ACT_READING) && in_range;
		slot_wr.idx       = IDX_W'(in_item.chan);
		slot_wr.data.valid  = 1'b1;
		slot_wr.data.cooler = in_item.cooler;
		slot_wr.data.temp   = in_item.ctemp;
		slot_wr.data.stamp  = in_item.now;
		alu_req.a   = item_q.now;
		alu_req.b   = last_warn_q;
		alu_req.sgn = 1'b0;
		case (state_q)
			ST_WARN_CMP: begin
				alu_req.a = work_q;
				alu_req.b = cfg.gap;
			end
			ST_AMB_GT: begin
				alu_req.a   = sx15(cfg.warm_min);
				alu_req.b   = sx15(item_q.amb);
				alu_req.sgn = 1'b1;
			end
			ST_AGE: begin
				alu_req.a = item_q.now;
				alu_req.b = slot_rd.stamp;
			end
			ST_STALE: begin
				alu_req.a = cfg.stale_limit;
				alu_req.b = work_q;
			end
			ST_COLD: begin
				alu_req.a   = sx15(slot_rd.temp);
				alu_req.b   = sx15(cfg.warm_min);
				alu_req.sgn = 1'b1;
			end
			ST_WARM: begin
				alu_req.a   = sx15(off_thr_q);
				alu_req.b   = sx15(slot_rd.temp);
				alu_req.sgn = 1'b1;
			end
			ST_DUR: begin
				alu_req.a = item_q.now;
				alu_req.b = since_eff;
			end
			ST_SETTLE: begin
				alu_req.a = work_q;
				alu_req.b = cfg.settle;
			end
			ST_AMB_LT: begin
				alu_req.a   = sx15(item_q.amb);
				alu_req.b   = sx15(cfg.warm_min);
				alu_req.sgn = 1'b1;
			end
			default: begin
				alu_req.a = item_q.now;
				alu_req.b = last_warn_q;
			end
		endcase
	end

	// Result word assembled from the flags gathered during the walk.
	always_comb begin
		out_res = '0;
		if (item_q.action == ACT_EVALUATE) begin
			if (mode_q != MODE_AUTO) begin
				out_res.heater_cmd = (mode_q == MODE_FORCE_ON) ? HEAT_ON : HEAT_OFF;
				out_res.warn       = warn_q;
			end else begin
				out_res.valid_total = 4'(valid_n_q);
				out_res.stale_total = 4'(stale_n_q);
				out_res.all_on      = all_on_q;
				out_res.dur         = work_q;
				out_res.cold        = cold_q;
				out_res.warm        = warm_q;
				out_res.bank_req    = entered_q && !item_q.powered;
				if (stale_n_q == CNT_W'(CHANNELS)) begin
					if (item_q.amb_valid && amb_lt_q) begin
						out_res.bank_req = 1'b1;
					end else begin
						out_res.heater_cmd = HEAT_OFF;
					end
				end else if (cold_q) begin
					out_res.heater_cmd = HEAT_ON;
				end else if (warm_q || (all_on_q && settle_ok_q)) begin
					out_res.heater_cmd = HEAT_OFF;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			all_on_since_q <= '0;
			last_warn_q    <= '0;
			prior_mode_q   <= MODE_AUTO;
			prior_known_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && in_item.action == ACT_EVALUATE) begin
				prior_mode_q  <= cfg.mode;
				prior_known_q <= 1'b1;
			end
			if (state_q == ST_WARN_CMP && !(last_warn_q != 32'd0 && alu_lt)) begin
				last_warn_q <= item_q.now;
			end
			if (state_q == ST_DUR) begin
				all_on_since_q <= all_fresh_on ? since_eff : 32'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q      <= in_item;
			mode_q      <= cfg.mode;
			ch_q        <= '0;
			valid_n_q   <= '0;
			stale_n_q   <= '0;
			all_en_q    <= 1'b1;
			all_on_q    <= 1'b0;
			cold_q      <= 1'b0;
			warm_q      <= 1'b0;
			warn_q      <= 1'b0;
			settle_ok_q <= 1'b0;
			amb_lt_q    <= 1'b0;
			work_q      <= '0;
			off_thr_q   <= cfg.cold_off;
			entered_q   <= (cfg.mode == MODE_AUTO) &&
				(!prior_known_q || prior_mode_q != MODE_AUTO);
		end
		case (state_q)
			ST_WARN_SUB: work_q <= alu_diff;
			ST_WARN_CMP: warn_q <= !(last_warn_q != 32'd0 && alu_lt);
			ST_AMB_GT: begin
				if (item_q.amb_valid && alu_lt) begin
					off_thr_q <= cfg.warm_min;
				end
			end
			ST_AGE: begin
				work_q <= alu_diff;
				if (!slot_rd.valid || slot_rd.stamp == 32'd0) begin
					stale_n_q <= stale_n_q + CNT_W'(1);
					all_en_q  <= 1'b0;
					ch_q      <= ch_q + IDX_W'(1);
				end
			end
			ST_STALE: begin
				if (alu_lt) begin
					stale_n_q <= stale_n_q + CNT_W'(1);
					all_en_q  <= 1'b0;
					ch_q      <= ch_q + IDX_W'(1);
				end else begin
					valid_n_q <= valid_n_q + CNT_W'(1);
					if (slot_rd.cooler) begin
						ch_q <= ch_q + IDX_W'(1);
					end else begin
						all_en_q <= 1'b0;
					end
				end
			end
			ST_COLD: begin
				if (alu_lt) begin
					cold_q <= 1'b1;
				end
			end
			ST_WARM: begin
				if (alu_lt) begin
					warm_q <= 1'b1;
				end
				ch_q <= ch_q + IDX_W'(1);
			end
			ST_DUR: begin
				all_on_q <= all_fresh_on;
				work_q   <= all_fresh_on ? alu_diff : 32'd0;
			end
			ST_SETTLE: settle_ok_q <= !alu_lt;
			ST_AMB_LT: amb_lt_q    <= alu_lt;
			default: begin
			end
		endcase
	end

endmodule

// File: design/heater_prewarm_policy.sv
// From acceptance to the result register: a reading word goes straight to the done state;
// an override evaluate takes a gap subtract and a compare; an auto evaluate takes one shared
// compare per cycle, one to four per channel slot, plus ambient, duration, settle, ambient-low.
// Throughput: one word at a time; the next is taken the cycle after the result register
// loads, later if the result waits.
// Reset clears slot valid bits, timers, mode history and output valid; registers get defaults.
module heater_prewarm_policy (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// tdata, low bit up: channel_index[3], cooler_on[1], channel_temp[15], now_ms[32],
	// amb_ok[1], ambient_temp[15], bank_on[1], zero fill.
	input  logic [hpp_pkg::IN_DATA_W-1:0]     s_tdata,
	// tuser: action[1].
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tdata, low bit up: heater_cmd[2], bank_power_request[1], warning_emit[1],
	// valid_total[4], stale_total[4], all_coolers_on[1], all_on_duration_ms[32],
	// any_cold_disabled[1], any_warm_disabled[1], zero fill.
	output logic [hpp_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [hpp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_wdata
);
	import hpp_pkg::*;

	cfg_t             cfg_q;
	item_t            in_item;
	slot_wr_t         slot_wr;
	logic [IDX_W-1:0] slot_idx;
	slot_t            slot_rd;
	alu_req_t         alu_req;
	logic [31:0]      alu_diff;
	logic             alu_lt;
	logic             out_free;
	logic             out_load;
	result_t          out_res;
	logic             m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	assign in_item.action    = s_tuser;
	assign in_item.chan      = s_tdata[2:0];
	assign in_item.cooler    = s_tdata[3];
	assign in_item.ctemp     = s_tdata[18:4];
	assign in_item.now       = s_tdata[50:19];
	assign in_item.amb_valid = s_tdata[51];
	assign in_item.amb       = s_tdata[66:52];
	assign in_item.powered   = s_tdata[67];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_AUTO;
			cfg_q.warm_min    <= 15'd240;
			cfg_q.cold_off    <= 15'd320;
			cfg_q.stale_limit <= 32'd5000;
			cfg_q.settle      <= 32'd1000;
			cfg_q.gap         <= 32'd60000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: begin
					if (cfg_wdata[1:0] != MODE_UNUSED) begin
						cfg_q.mode <= cfg_wdata[1:0];
					end
				end
				REG_WARM_MIN: cfg_q.warm_min    <= cfg_wdata[14:0];
				REG_COLD_OFF: cfg_q.cold_off    <= cfg_wdata[14:0];
				REG_STALE:    cfg_q.stale_limit <= cfg_wdata;
				REG_SETTLE:   cfg_q.settle      <= cfg_wdata;
				REG_GAP:      cfg_q.gap         <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	hpp_slot_store u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (slot_wr),
		.rd_idx  (slot_idx),
		.rd_data (slot_rd)
	);

	hpp_sub_cmp u_alu (
		.req  (alu_req),
		.diff (alu_diff),
		.lt   (alu_lt)
	);

	hpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.slot_wr  (slot_wr),
		.slot_idx (slot_idx),
		.slot_rd  (slot_rd),
		.alu_req  (alu_req),
		.alu_diff (alu_diff),
		.alu_lt   (alu_lt),
		.out_free (out_free),
		.out_load (out_load),
		.out_res  (out_res)
	);

	// The output register frees up in the same cycle its word is taken.
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {1'b0, out_res.warm, out_res.cold, out_res.dur, out_res.all_on,
				out_res.stale_total, out_res.valid_total, out_res.warn,
				out_res.bank_req, out_res.heater_cmd};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
